@@ hdl/wto_pkg.sv @@
// wto_pkg: shared constants, register codes and the build-time sine table
// for the wavetable oscillator; no dependencies
`timescale 1ns / 1ps

package wto_pkg;

  // table geometry, table length must be a power of two
  localparam int TABLE_LENGTH = 1024;
  localparam int TABLE_BITS   = $clog2(TABLE_LENGTH);
  localparam int QUARTER_LEN  = TABLE_LENGTH / 4;
  localparam int QUARTER_BITS = TABLE_BITS - 2;

  localparam int DEF_PHASE_FRAC_BITS = 22;
  localparam int DEF_SAMPLE_BITS     = 16;
  localparam int MAX_SAMPLE_BITS     = 24;

  localparam int FREQ_BITS      = 24;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  // register map
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_SCALE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_PHASE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INTERPOLATE = 2'd2;

  localparam logic [31:0] PHASE_SCALE_RESET = 32'd91625969;
  localparam logic [31:0] START_PHASE_RESET = 32'd0;
  localparam logic        INTERPOLATE_RESET = 1'b1;

  typedef logic [63:0] u64_t;
  typedef u64_t coef_t [7];
  typedef logic signed [MAX_SAMPLE_BITS-1:0] qtab_t [QUARTER_LEN];

  // taylor terms of sin(pi/2 * t) in q30, highest order first
  localparam coef_t SIN_COEF = '{
    64'd61, 64'd3865, 64'd172272, 64'd5026995,
    64'd85569305, 64'd693598668, 64'd1686629713
  };

  // first quarter wave, evaluated at elaboration only
  function automatic qtab_t sine_quarter(input int sample_bits);
    qtab_t tab;
    u64_t  amp;
    u64_t  x;
    u64_t  t2;
    u64_t  acc;
    u64_t  s;
    u64_t  v;
    int    i;
    int    k;
    amp = (64'd1 << (sample_bits - 1)) - 64'd1;
    for (i = 0; i < QUARTER_LEN; i++) begin
      x   = u64_t'(i) << (32 - TABLE_BITS);
      t2  = (x * x) >> 30;
      acc = SIN_COEF[0];
      for (k = 1; k < 7; k++) begin
        acc = SIN_COEF[k] - ((t2 * acc) >> 30);
      end
      s = (x * acc) >> 30;
      v = (s * amp + (64'd1 << 29)) >> 30;
      if (v > amp) begin
        v = amp;
      end
      tab[i] = v[MAX_SAMPLE_BITS-1:0];
    end
    return tab;
  endfunction

endpackage

@@ hdl/wavetable_oscillator_unit.sv @@
// wavetable_oscillator_unit: sine wavetable oscillator with optional linear
// interpolation, phase accumulator and stream handshakes; uses wto_pkg
`timescale 1ns / 1ps

// One sample per input transfer, one transfer per clock when the output side
// keeps up. Each frequency word (signed q15.8 hertz) yields the sine sample at
// the current phase, then the phase advances by frequency * phase_scale and
// wraps around the table. The path is a seven stage pipeline: input register,
// split 24x16 partial products, step register, phase accumulator, table read,
// interpolation multiply, output register. Throughput is one item per cycle
// while the output keeps up, bounded by the phase accumulator, whose feedback
// is a single add. Each stage holds its item until the next frees up and
// bubbles close up, so the input keeps taking items while a finished sample
// waits on m_tready. The sine table is one quarter wave built at elaboration;
// the other quadrants come from folding the index and negating. A set tuser
// bit reloads the phase from start_phase before its own sample. Registers are
// written through the cfg channel (ready whenever out of reset) and should
// only change while no item is in flight. Neither s_tready nor cfg_ready is
// high during reset.
module wavetable_oscillator_unit #(
  parameter int PHASE_FRAC_BITS = wto_pkg::DEF_PHASE_FRAC_BITS,
  parameter int SAMPLE_BITS     = wto_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [wto_pkg::FREQ_BITS-1:0]      s_tdata,   // [23:0] frequency
  input  logic                               s_tuser,   // [0] restart
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,   // [SAMPLE_BITS-1:0] sample
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wto_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wto_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import wto_pkg::*;

  localparam int PHASE_W   = TABLE_BITS + PHASE_FRAC_BITS;
  localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PART_W    = FREQ_BITS + 16;
  localparam int FULL_W    = FREQ_BITS + 32;
  localparam int DIFF_W    = SAMPLE_BITS + 1;
  localparam int FRAC_S_W  = PHASE_FRAC_BITS + 1;
  localparam int PROD_W    = DIFF_W + FRAC_S_W;

  localparam logic signed [SAMPLE_BITS-1:0] AMP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (PHASE_FRAC_BITS - 1);

  localparam qtab_t QUARTER = sine_quarter(SAMPLE_BITS);

  // full-cycle lookup from the quarter wave
  function automatic logic signed [SAMPLE_BITS-1:0] sine_lookup(
    input logic [TABLE_BITS-1:0] idx
  );
    logic [QUARTER_BITS:0]           folded;
    logic signed [SAMPLE_BITS-1:0]   mag;
    if (idx[TABLE_BITS-2]) begin
      folded = (QUARTER_BITS+1)'(QUARTER_LEN) - {1'b0, idx[QUARTER_BITS-1:0]};
    end else begin
      folded = {1'b0, idx[QUARTER_BITS-1:0]};
    end
    // folded index at the quarter point is the peak
    if (folded[QUARTER_BITS]) begin
      mag = AMP;
    end else begin
      mag = SAMPLE_BITS'(QUARTER[folded[QUARTER_BITS-1:0]]);
    end
    return idx[TABLE_BITS-1] ? -mag : mag;
  endfunction

  // configuration registers
  logic [31:0] phase_scale;
  logic [31:0] start_phase;
  logic        interpolate;

  // pipeline registers, stage a to f, then the output register
  logic                          a_valid;
  logic [FREQ_BITS-1:0]          a_mag;
  logic                          a_neg;
  logic                          a_restart;

  logic                          b_valid;
  logic [PART_W-1:0]             b_plo;
  logic [PART_W-1:0]             b_phi;
  logic                          b_neg;
  logic                          b_restart;

  logic                          c_valid;
  logic [PHASE_W-1:0]            c_step;
  logic                          c_neg;
  logic                          c_restart;

  logic                          d_valid;
  logic [PHASE_W-1:0]            d_phase;

  logic                          e_valid;
  logic signed [SAMPLE_BITS-1:0] e_e0;
  logic signed [SAMPLE_BITS-1:0] e_e1;
  logic [PHASE_FRAC_BITS-1:0]    e_frac;

  logic                          f_valid;
  logic signed [SAMPLE_BITS-1:0] f_e0;
  logic signed [PROD_W-1:0]      f_prod;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic [PHASE_W-1:0]            phase_accum;

  // stage enables, an empty stage always takes the next item
  logic out_en, f_en, e_en, d_en, c_en, b_en, a_en;

  // combinational values between stages
  logic [FREQ_BITS-1:0]          freq_mag;
  logic [FULL_W-1:0]             full_prod;
  logic [PHASE_W-1:0]            step_next;
  logic [PHASE_W-1:0]            phase_load;
  logic [PHASE_W-1:0]            phase_cur;
  logic [PHASE_W-1:0]            phase_accum_next;
  logic [TABLE_BITS-1:0]         base_idx;
  logic [TABLE_BITS-1:0]         next_idx;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [FRAC_S_W-1:0]    frac_s;
  logic signed [PROD_W-1:0]      round_sum;
  logic signed [PROD_W-1:0]      round_shift;
  logic signed [SAMPLE_BITS-1:0] sample_next;

  assign out_en   = !m_tvalid || m_tready;
  assign f_en     = !f_valid || out_en;
  assign e_en     = !e_valid || f_en;
  assign d_en     = !d_valid || e_en;
  assign c_en     = !c_valid || d_en;
  assign b_en     = !b_valid || c_en;
  assign a_en     = !a_valid || b_en;
  // no transfer is taken while in reset
  assign s_tready = a_en && !rst;

  assign cfg_ready = !rst;
  assign m_tdata   = TDATA_W'($unsigned(sample));

  // magnitude of the two's complement frequency, the most negative code fits
  assign freq_mag = s_tdata[FREQ_BITS-1] ? (~s_tdata + FREQ_BITS'(1)) : s_tdata;

  // step is the product shifted down to phase units, wrapped by truncation
  assign full_prod = {b_phi, 16'b0} + FULL_W'(b_plo);
  assign step_next = PHASE_W'(full_prod >> (40 - PHASE_FRAC_BITS));

  // start phase scaled by the table length
  assign phase_load = PHASE_W'({start_phase, {TABLE_BITS{1'b0}}} >> (32 - PHASE_FRAC_BITS));
  assign phase_cur  = c_restart ? phase_load : phase_accum;
  assign phase_accum_next = c_neg ? (phase_cur - c_step) : (phase_cur + c_step);

  // neighbor index wraps past the last entry
  assign base_idx = d_phase[PHASE_W-1:PHASE_FRAC_BITS];
  assign next_idx = base_idx + TABLE_BITS'(1);

  assign diff   = DIFF_W'(e_e1) - DIFF_W'(e_e0);
  assign frac_s = $signed({1'b0, e_frac});

  // round half up, arithmetic shift floors
  assign round_sum   = f_prod + ROUND_HALF;
  assign round_shift = round_sum >>> PHASE_FRAC_BITS;
  assign sample_next = interpolate ? (f_e0 + SAMPLE_BITS'(round_shift)) : f_e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_scale <= PHASE_SCALE_RESET;
      start_phase <= START_PHASE_RESET;
      interpolate <= INTERPOLATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_SCALE: phase_scale <= cfg_data;
        REG_START_PHASE: start_phase <= cfg_data;
        REG_INTERPOLATE: interpolate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // valid bits and the phase accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      d_valid     <= 1'b0;
      e_valid     <= 1'b0;
      f_valid     <= 1'b0;
      m_tvalid    <= 1'b0;
      phase_accum <= '0;
    end else begin
      if (a_en)   a_valid  <= s_tvalid;
      if (b_en)   b_valid  <= a_valid;
      if (c_en)   c_valid  <= b_valid;
      if (d_en)   d_valid  <= c_valid;
      if (e_en)   e_valid  <= d_valid;
      if (f_en)   f_valid  <= e_valid;
      if (out_en) m_tvalid <= f_valid;
      // the accumulator moves once per item leaving the step stage
      if (c_valid && d_en) begin
        phase_accum <= phase_accum_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (a_en) begin
      a_mag     <= freq_mag;
      a_neg     <= s_tdata[FREQ_BITS-1];
      a_restart <= s_tuser;
    end
    if (b_en) begin
      // 24x32 product as two 24x16 halves
      b_plo     <= PART_W'(a_mag) * PART_W'(phase_scale[15:0]);
      b_phi     <= PART_W'(a_mag) * PART_W'(phase_scale[31:16]);
      b_neg     <= a_neg;
      b_restart <= a_restart;
    end
    if (c_en) begin
      c_step    <= step_next;
      c_neg     <= b_neg;
      c_restart <= b_restart;
    end
    if (d_en) begin
      d_phase <= phase_cur;
    end
    if (e_en) begin
      e_e0   <= sine_lookup(base_idx);
      e_e1   <= sine_lookup(next_idx);
      e_frac <= d_phase[PHASE_FRAC_BITS-1:0];
    end
    if (f_en) begin
      f_e0   <= e_e0;
      f_prod <= PROD_W'(diff) * PROD_W'(frac_s);
    end
    if (out_en) begin
      sample <= sample_next;
    end
  end

`ifndef NO_ASSERTIONS
  // accumulator adds the step of a non-restart, positive-step item leaving the step stage
  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    (c_valid && d_en && !c_restart && !c_neg)
      |=> (phase_accum == $past(PHASE_W'(phase_accum + c_step))))
    else $error("phase accumulator did not advance by the step");

  // a restart item samples at the loaded start phase
  a_restart_load: assert property (@(posedge clk) disable iff (rst)
    (c_valid && d_en && c_restart) |=> (d_phase == $past(phase_load)))
    else $error("restart did not load the start phase");

  // input stalls only when every stage is full and the output is blocked
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (a_valid && b_valid && c_valid && d_valid && e_valid && f_valid
                   && m_tvalid && !m_tready))
    else $error("input stalled with room in the pipeline");

  // a new output comes only from a full last stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(f_valid))
    else $error("output valid without an item in the last stage");
`endif

endmodule
